// ===== hw/rtl/ped_pkg.sv =====
// Package for the pairwise Euclidean distance block.
// Widths, sizing constants, codes and the sequencer state type. No dependencies.
package ped_pkg;

    localparam int MAX_POINTS = 256;
    localparam int MAX_DIMS   = 16;

    localparam int ACTION_W = 1;
    localparam int POINT_W  = 8;
    localparam int DIM_W    = 4;
    localparam int COORD_W  = 16;
    localparam int DIST_W   = 18;
    localparam int STATUS_W = 1;

    localparam int NPTS_W     = 9;
    localparam int NDIM_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS   = 1'd1;

    localparam logic [NPTS_W-1:0] NPTS_RESET = 9'd256;
    localparam logic [NDIM_W-1:0] NDIM_RESET = 5'd16;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 1'b0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 1'b1;

    localparam int DIST_MAX = 262143;

    localparam int DEPTH    = MAX_POINTS * MAX_DIMS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int DCNT_W   = $clog2(MAX_DIMS + 1);
    localparam int PROD_W   = 2 * COORD_W;
    localparam int SUM_W    = PROD_W + $clog2(MAX_DIMS + 1);
    localparam int SQ_STEPS = (SUM_W + 1) / 2;
    localparam int RAD_W    = 2 * SQ_STEPS;
    localparam int REM_W    = SQ_STEPS + 2;
    localparam int SCNT_W   = $clog2(SQ_STEPS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAC  = 4'b0010,
        S_SQRT = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

endpackage

// ===== hw/rtl/ped_item_if.sv =====
// Input channel of the pairwise Euclidean distance block: valid/ready plus payload.
// Depends on ped_pkg.
interface ped_item_if;
    logic                          valid;
    logic                          ready;
    logic [ped_pkg::ACTION_W-1:0]  action;
    logic [ped_pkg::POINT_W-1:0]   first_point;
    logic [ped_pkg::POINT_W-1:0]   second_point;
    logic [ped_pkg::DIM_W-1:0]     dim_index;
    logic signed [ped_pkg::COORD_W-1:0] coord_value;

    modport source (output valid, action, first_point, second_point, dim_index,
                    coord_value, input ready);
    modport sink   (input valid, action, first_point, second_point, dim_index,
                    coord_value, output ready);
endinterface

interface ped_result_if;
    logic                          valid;
    logic                          ready;
    logic [ped_pkg::DIST_W-1:0]    distance;
    logic [ped_pkg::POINT_W-1:0]   first_echo;
    logic [ped_pkg::POINT_W-1:0]   second_echo;
    logic [ped_pkg::STATUS_W-1:0]  status;

    modport source (output valid, distance, first_echo, second_echo, status,
                    input ready);
    modport sink   (input valid, distance, first_echo, second_echo, status,
                    output ready);
endinterface

// ===== hw/rtl/pairwise_euclidean_distance.sv =====
// Top level of the pairwise Euclidean distance block: coordinate store,
// multiply-accumulate sequencer and bit-serial square root.
// Depends on ped_pkg, ped_item_if and ped_result_if.

// Loads may be sent back to back. A query runs the multiply-accumulate loop
// (one coordinate pair read from the two-port store per cycle, one 16x16
// multiplier), then the square root unit (one root bit per cycle, SQ_STEPS
// root bits, 19 at the default sizing), then posts the result to the output
// register. A query with an out-of-range point skips both loops. The input
// is held off while a query is in progress; a finished result waits in the
// output register without blocking new loads.
module pairwise_euclidean_distance (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ped_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [ped_pkg::CFG_DATA_W-1:0] cfg_data,
    ped_item_if.sink                       item,
    ped_result_if.source                   result
);

    ped_pkg::state_t state_reg, state_next;

    logic [ped_pkg::NPTS_W-1:0] num_points_reg;
    logic [ped_pkg::NDIM_W-1:0] num_dims_reg;

    logic [ped_pkg::COORD_W-1:0] mem [ped_pkg::DEPTH];
    logic [ped_pkg::COORD_W-1:0] rdata_a_reg, rdata_b_reg;

    logic [ped_pkg::POINT_W-1:0] p_reg, q_reg;
    logic [ped_pkg::DCNT_W-1:0]  nd_reg, k_reg;
    logic                        rd_vld_reg, mul_vld_reg;
    logic [ped_pkg::PROD_W-1:0]  prod_reg;
    logic [ped_pkg::SUM_W-1:0]   sum_reg;
    logic [ped_pkg::STATUS_W-1:0] status_reg;

    logic [ped_pkg::RAD_W-1:0]    rad_reg;
    logic [ped_pkg::REM_W-1:0]    rem_reg;
    logic [ped_pkg::SQ_STEPS-1:0] root_reg;
    logic [ped_pkg::SCNT_W-1:0]   scnt_reg;

    logic                          out_valid_reg;
    logic [ped_pkg::DIST_W-1:0]    out_dist_reg;
    logic [ped_pkg::POINT_W-1:0]   out_first_reg, out_second_reg;
    logic [ped_pkg::STATUS_W-1:0]  out_status_reg;

    logic item_xfer, load_xfer, query_xfer, load_ok, oob, rd_en, mac_done, fin_load;
    logic [ped_pkg::DCNT_W-1:0]   nd_eff;
    logic [ped_pkg::ADDR_W-1:0]   wr_addr, rd_addr_a, rd_addr_b;
    logic signed [ped_pkg::COORD_W:0] diff;
    logic [ped_pkg::COORD_W-1:0]  mag;
    logic [ped_pkg::REM_W-1:0]    rem_shift, trial;
    logic                         take;
    logic [ped_pkg::DIST_W-1:0]   dist_sat;

    assign item.ready = (state_reg == ped_pkg::S_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign load_xfer  = item_xfer && (item.action == ped_pkg::ACT_LOAD);
    assign query_xfer = item_xfer && (item.action == ped_pkg::ACT_QUERY);

    assign load_ok = (32'(item.first_point) < ped_pkg::MAX_POINTS)
                  && (32'(item.dim_index) < ped_pkg::MAX_DIMS);
    assign wr_addr = ped_pkg::ADDR_W'(32'(item.first_point) * ped_pkg::MAX_DIMS
                                      + 32'(item.dim_index));

    always_comb
    begin
        if (32'(num_points_reg) > ped_pkg::MAX_POINTS)
        begin
            oob = (32'(item.first_point) >= ped_pkg::MAX_POINTS)
               || (32'(item.second_point) >= ped_pkg::MAX_POINTS);
        end
        else
        begin
            oob = (32'(item.first_point) >= 32'(num_points_reg))
               || (32'(item.second_point) >= 32'(num_points_reg));
        end
        if (32'(num_dims_reg) > ped_pkg::MAX_DIMS)
        begin
            nd_eff = ped_pkg::DCNT_W'(ped_pkg::MAX_DIMS);
        end
        else
        begin
            nd_eff = ped_pkg::DCNT_W'(num_dims_reg);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= ped_pkg::NPTS_RESET;
            num_dims_reg   <= ped_pkg::NDIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                ped_pkg::CFG_NUM_POINTS: num_points_reg <= cfg_data[ped_pkg::NPTS_W-1:0];
                ped_pkg::CFG_NUM_DIMS:   num_dims_reg   <= cfg_data[ped_pkg::NDIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Coordinate store: one write port, two registered read ports
    assign rd_en     = (state_reg == ped_pkg::S_MAC) && (k_reg < nd_reg);
    assign rd_addr_a = ped_pkg::ADDR_W'(32'(p_reg) * ped_pkg::MAX_DIMS + 32'(k_reg));
    assign rd_addr_b = ped_pkg::ADDR_W'(32'(q_reg) * ped_pkg::MAX_DIMS + 32'(k_reg));

    always_ff @(posedge clk)
    begin
        if (load_xfer && load_ok)
        begin
            mem[wr_addr] <= item.coord_value;
        end
        if (rd_en)
        begin
            rdata_a_reg <= mem[rd_addr_a];
            rdata_b_reg <= mem[rd_addr_b];
        end
    end

    // Difference, magnitude, square
    assign diff = $signed({rdata_a_reg[ped_pkg::COORD_W-1], rdata_a_reg})
                - $signed({rdata_b_reg[ped_pkg::COORD_W-1], rdata_b_reg});
    assign mag  = diff[ped_pkg::COORD_W] ? ped_pkg::COORD_W'(-diff)
                                         : ped_pkg::COORD_W'(diff);

    assign mac_done = (k_reg == nd_reg) && !rd_vld_reg && !mul_vld_reg;

    // Square root step: two radicand bits in, one root bit out
    assign rem_shift = {rem_reg[ped_pkg::REM_W-3:0], rad_reg[ped_pkg::RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_shift >= trial);

    assign dist_sat = (32'(root_reg) > ped_pkg::DIST_MAX) ? ped_pkg::DIST_W'(ped_pkg::DIST_MAX)
                                                          : ped_pkg::DIST_W'(root_reg);

    assign fin_load = (state_reg == ped_pkg::S_FIN) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ped_pkg::S_IDLE:
            begin
                if (query_xfer)
                begin
                    state_next = oob ? ped_pkg::S_FIN : ped_pkg::S_MAC;
                end
            end
            ped_pkg::S_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ped_pkg::S_SQRT;
                end
            end
            ped_pkg::S_SQRT:
            begin
                if (scnt_reg == ped_pkg::SCNT_W'(ped_pkg::SQ_STEPS - 1))
                begin
                    state_next = ped_pkg::S_FIN;
                end
            end
            ped_pkg::S_FIN:
            begin
                if (fin_load)
                begin
                    state_next = ped_pkg::S_IDLE;
                end
            end
            default: state_next = ped_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ped_pkg::S_IDLE;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_en;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (query_xfer)
        begin
            p_reg      <= item.first_point;
            q_reg      <= item.second_point;
            nd_reg     <= nd_eff;
            k_reg      <= '0;
            sum_reg    <= '0;
            root_reg   <= '0;
            status_reg <= oob ? ped_pkg::STAT_RANGE : ped_pkg::STAT_OK;
        end
        else if (state_reg == ped_pkg::S_MAC)
        begin
            if (rd_en)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (rd_vld_reg)
            begin
                prod_reg <= mag * mag;
            end
            if (mul_vld_reg)
            begin
                sum_reg <= sum_reg + ped_pkg::SUM_W'(prod_reg);
            end
            if (mac_done)
            begin
                rad_reg  <= ped_pkg::RAD_W'(sum_reg);
                rem_reg  <= '0;
                root_reg <= '0;
                scnt_reg <= '0;
            end
        end
        else if (state_reg == ped_pkg::S_SQRT)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[ped_pkg::SQ_STEPS-2:0], take};
            scnt_reg <= scnt_reg + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            out_dist_reg   <= dist_sat;
            out_first_reg  <= p_reg;
            out_second_reg <= q_reg;
            out_status_reg <= status_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.distance    = out_dist_reg;
    assign result.first_echo  = out_first_reg;
    assign result.second_echo = out_second_reg;
    assign result.status      = out_status_reg;

`ifndef NO_ASSERTIONS
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status == ped_pkg::STAT_RANGE) |-> result.distance == '0)
        else $error("out-of-range query with nonzero distance");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_xfer |=> !item.ready)
        else $error("input ready right after query transfer");

    a_sqrt_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ped_pkg::S_SQRT) |-> (32'(scnt_reg) < ped_pkg::SQ_STEPS))
        else $error("square root step count overrun");

    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ped_pkg::S_FIN)
        else $error("result posted outside final state");

    a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ped_pkg::S_SQRT) |-> !rd_vld_reg && !mul_vld_reg)
        else $error("accumulate pipeline busy during square root");
`endif

endmodule

// ===== bench/pairwise_euclidean_distance_tb.sv =====
// Self-checking bench for pairwise_euclidean_distance: coordinate loads and distance
// queries under several geometries and handshake idle patterns, scored against a mirror.
// Depends on ped_pkg, ped_item_if, ped_result_if and the block itself.
module pairwise_euclidean_distance_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ped_pkg::DIST_W-1:0]   distance;
        logic [ped_pkg::POINT_W-1:0]  first_echo;
        logic [ped_pkg::POINT_W-1:0]  second_echo;
        logic [ped_pkg::STATUS_W-1:0] status;
    } dist_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [ped_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [ped_pkg::CFG_DATA_W-1:0] cfg_data;

    ped_item_if   item_ch();
    ped_result_if result_ch();

    pairwise_euclidean_distance dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    logic [ped_pkg::COORD_W-1:0]  coord_mirror [0:ped_pkg::DEPTH-1];
    logic [ped_pkg::MAX_DIMS-1:0] dims_loaded [0:ped_pkg::MAX_POINTS-1];
    logic [ped_pkg::NPTS_W-1:0]   npts_reg;
    logic [ped_pkg::NDIM_W-1:0]   ndim_reg;
    dist_result_t                 pending_dist [$];
    int                           src_idle_pct = 0;
    int                           sink_stall_pct = 0;
    int                           mismatch_count = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    function automatic int eff_points();
        return (npts_reg > ped_pkg::MAX_POINTS) ? ped_pkg::MAX_POINTS : int'(npts_reg);
    endfunction

    function automatic logic [ped_pkg::DIST_W-1:0] floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 19; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        if (r > ped_pkg::DIST_MAX)
            r = ped_pkg::DIST_MAX;
        return r[ped_pkg::DIST_W-1:0];
    endfunction

    function automatic dist_result_t euclid_between(input logic [ped_pkg::POINT_W-1:0] p,
                                                    input logic [ped_pkg::POINT_W-1:0] q);
        dist_result_t    r;
        longint unsigned acc;
        int              a;
        int              b;
        int              diff;
        int              nd;
        r.first_echo  = p;
        r.second_echo = q;
        r.distance    = '0;
        r.status      = ped_pkg::STAT_OK;
        nd = (ndim_reg > ped_pkg::MAX_DIMS) ? ped_pkg::MAX_DIMS : int'(ndim_reg);
        if (int'(p) >= eff_points() || int'(q) >= eff_points())
        begin
            r.status = ped_pkg::STAT_RANGE;
            return r;
        end
        acc = 0;
        for (int k = 0; k < nd; k++)
        begin
            a    = $signed(coord_mirror[int'(p) * ped_pkg::MAX_DIMS + k]);
            b    = $signed(coord_mirror[int'(q) * ped_pkg::MAX_DIMS + k]);
            diff = a - b;
            acc += longint'(diff) * longint'(diff);
        end
        r.distance = floor_root(acc);
        return r;
    endfunction

    function automatic void note_transfer(input logic [ped_pkg::ACTION_W-1:0] act,
                                          input logic [ped_pkg::POINT_W-1:0] p,
                                          input logic [ped_pkg::POINT_W-1:0] q,
                                          input logic [ped_pkg::DIM_W-1:0] d,
                                          input logic [ped_pkg::COORD_W-1:0] v);
        if (act == ped_pkg::ACT_LOAD)
        begin
            coord_mirror[int'(p) * ped_pkg::MAX_DIMS + int'(d)] = v;
            dims_loaded[p][d] = 1'b1;
        end
        else
            pending_dist.push_back(euclid_between(p, q));
    endfunction

    function automatic logic [ped_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return ped_pkg::COORD_W'($urandom);
        endcase
    endfunction

    // random fully loaded point below limit, -1 if there is none
    function automatic int pick_loaded(input int limit);
        int cand [$];
        for (int i = 0; i < limit && i < ped_pkg::MAX_POINTS; i++)
            if (dims_loaded[i] == '1)
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(cand.size() - 1)];
    endfunction

    task automatic send_item(input logic [ped_pkg::ACTION_W-1:0] act,
                             input logic [ped_pkg::POINT_W-1:0] p,
                             input logic [ped_pkg::POINT_W-1:0] q,
                             input logic [ped_pkg::DIM_W-1:0] d,
                             input logic [ped_pkg::COORD_W-1:0] v);
        if ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle_pct)
                @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= act;
        item_ch.first_point  <= p;
        item_ch.second_point <= q;
        item_ch.dim_index    <= d;
        item_ch.coord_value  <= v;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        note_transfer(act, p, q, d, v);
    endtask

    task automatic load_coord(input logic [ped_pkg::POINT_W-1:0] p,
                              input logic [ped_pkg::DIM_W-1:0] d,
                              input logic [ped_pkg::COORD_W-1:0] v);
        send_item(ped_pkg::ACT_LOAD, p, ped_pkg::POINT_W'($urandom), d, v);
    endtask

    task automatic query_pair(input logic [ped_pkg::POINT_W-1:0] p,
                              input logic [ped_pkg::POINT_W-1:0] q);
        send_item(ped_pkg::ACT_QUERY, p, q, ped_pkg::DIM_W'($urandom),
                  ped_pkg::COORD_W'($urandom));
    endtask

    task automatic fill_point(input logic [ped_pkg::POINT_W-1:0] p);
        int                          style;
        logic [ped_pkg::COORD_W-1:0] v;
        style = $urandom_range(9);
        for (int d = 0; d < ped_pkg::MAX_DIMS; d++)
        begin
            v = (style == 0) ? 16'h8000 : (style == 1) ? 16'h7FFF : rand_coord();
            load_coord(p, ped_pkg::DIM_W'(d), v);
        end
    endtask

    // drop valid, wait for every outstanding query, then let the pipe empty
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_geometry(input int np, input int nd);
        cfg_we   <= 1'b1;
        cfg_idx  <= ped_pkg::CFG_NUM_POINTS;
        cfg_data <= ped_pkg::CFG_DATA_W'(np);
        @(posedge clk);
        cfg_idx  <= ped_pkg::CFG_NUM_DIMS;
        cfg_data <= ped_pkg::CFG_DATA_W'(nd);
        @(posedge clk);
        cfg_we   <= 1'b0;
        npts_reg = ped_pkg::NPTS_W'(np);
        ndim_reg = ped_pkg::NDIM_W'(nd);
    endtask

    task automatic test_extreme_coords();
        set_geometry(256, 2);
        load_coord(8'd0, 4'd0, 16'h8000);
        load_coord(8'd0, 4'd1, 16'h8000);
        load_coord(8'd255, 4'd0, 16'h7FFF);
        load_coord(8'd255, 4'd1, 16'h7FFF);
        load_coord(8'd128, 4'd0, 16'h0100);
        load_coord(8'd128, 4'd1, 16'hFF00);
        query_pair(8'd0, 8'd255);
        query_pair(8'd255, 8'd255);
        query_pair(8'd128, 8'd0);
        query_pair(8'd255, 8'd128);
        settle();
        // count above the table size saturates
        set_geometry(511, 1);
        query_pair(8'd0, 8'd255);
        settle();
    endtask

    task automatic test_index_range();
        set_geometry(1, 2);
        query_pair(8'd0, 8'd0);
        query_pair(8'd0, 8'd255);
        query_pair(8'd255, 8'd0);
        query_pair(8'd1, 8'd1);
        settle();
        set_geometry(0, 2);
        query_pair(8'd0, 8'd0);
        settle();
    endtask

    task automatic test_zero_dims();
        set_geometry(256, 0);
        query_pair(8'd0, 8'd255);
        query_pair(8'd37, 8'd200);
        settle();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int np, input int nd, input int budget);
        int sent;
        int roll;
        int lim;
        int p;
        int q;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        set_geometry(np, nd);
        lim  = eff_points();
        sent = 0;
        while (sent < budget)
        begin
            roll = $urandom_range(99);
            p    = pick_loaded(lim);
            if (p < 0 || roll < 8)
            begin
                fill_point(ped_pkg::POINT_W'($urandom_range(lim - 1)));
                sent += ped_pkg::MAX_DIMS;
            end
            else if (roll < 22)
            begin
                load_coord(ped_pkg::POINT_W'($urandom), ped_pkg::DIM_W'($urandom),
                           rand_coord());
                sent++;
            end
            else if (roll < 34 && lim < ped_pkg::MAX_POINTS)
            begin
                q = $urandom_range(ped_pkg::MAX_POINTS - 1, lim);
                if (roll[0])
                    query_pair(ped_pkg::POINT_W'(p), ped_pkg::POINT_W'(q));
                else
                    query_pair(ped_pkg::POINT_W'(q), ped_pkg::POINT_W'($urandom));
                sent++;
            end
            else
            begin
                q = (roll < 45) ? p : pick_loaded(lim);
                query_pair(ped_pkg::POINT_W'(p), ped_pkg::POINT_W'(q));
                sent++;
            end
        end
        settle();
    endtask

    always @(posedge clk)
    begin : result_check
        dist_result_t want;
        dist_result_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.distance    = result_ch.distance;
            got.first_echo  = result_ch.first_echo;
            got.second_echo = result_ch.second_echo;
            got.status      = result_ch.status;
            if (pending_dist.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result dist=%0d pts=%0d,%0d status=%0d",
                             $realtime, got.distance, got.first_echo, got.second_echo,
                             got.status);
            end
            else
            begin
                want = pending_dist.pop_front();
                if (got.distance !== want.distance || got.first_echo !== want.first_echo ||
                    got.second_echo !== want.second_echo || got.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: exp %0d %0d,%0d st %0d got %0d %0d,%0d st %0d",
                                 $realtime, want.distance, want.first_echo,
                                 want.second_echo, want.status, got.distance,
                                 got.first_echo, got.second_echo, got.status);
                end
            end
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= ped_pkg::CFG_NUM_POINTS;
        cfg_data             <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.action       <= ped_pkg::ACT_LOAD;
        item_ch.first_point  <= '0;
        item_ch.second_point <= '0;
        item_ch.dim_index    <= '0;
        item_ch.coord_value  <= '0;
        for (int i = 0; i < ped_pkg::MAX_POINTS; i++)
            dims_loaded[i] = '0;
        npts_reg = ped_pkg::NPTS_RESET;
        ndim_reg = ped_pkg::NDIM_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_coords();
        test_index_range();
        test_zero_dims();
        test_random_traffic(0, 0, 256, 16, 110);
        test_random_traffic(45, 0, $urandom_range(256, 2), $urandom_range(16, 1), 110);
        test_random_traffic(0, 45, 511, 31, 110);
        test_random_traffic(21, 21, $urandom_range(128, 1), $urandom_range(15, 1), 110);

        if (pending_dist.size() != 0)
        begin
            $display("%0d queries never answered", pending_dist.size());
            mismatch_count += pending_dist.size();
        end
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
